[rtl/bdr_pkg.sv]
package bdr_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned FracBits  = 32;
  localparam int unsigned MaxCols   = 6;
  localparam int unsigned NumStages = 7;
  localparam int unsigned DivW      = 10;
  localparam int unsigned ProdW     = 2 * WordW;
  localparam int unsigned WideW     = 72;

  localparam logic signed [WordW-1:0] WordHi = {1'b0, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] WordLo = {1'b1, {(WordW-1){1'b0}}};
  localparam logic signed [WideW-1:0] WideHi = WideW'(WordHi);
  localparam logic signed [WideW-1:0] WideLo = WideW'(WordLo);

  localparam logic [1:0] CfgStepSize  = 2'd0;
  localparam logic [1:0] CfgStepCount = 2'd1;
  localparam logic [1:0] CfgColumns   = 2'd2;

  localparam logic signed [7:0] StageCoef [NumStages][NumStages] = '{
    '{8'sd1,   8'sd0,   8'sd0,  8'sd0,   8'sd0,   8'sd0,   8'sd0},
    '{8'sd0,   8'sd2,   8'sd0,  8'sd0,   8'sd0,   8'sd0,   8'sd0},
    '{8'sd1,   8'sd4,  -8'sd1,  8'sd0,   8'sd0,   8'sd0,   8'sd0},
    '{-8'sd1,  8'sd18, -8'sd3, -8'sd6,   8'sd0,   8'sd0,   8'sd0},
    '{8'sd0,   8'sd9,  -8'sd3, -8'sd6,   8'sd4,   8'sd0,   8'sd0},
    '{8'sd9,  -8'sd36,  8'sd63, 8'sd72,  8'sd0,  -8'sd64,  8'sd0},
    '{8'sd11,  8'sd0,   8'sd81, 8'sd81, -8'sd32, -8'sd32,  8'sd11}
  };
  localparam logic [DivW-1:0] StageDiv [NumStages] = '{
    10'd3, 10'd3, 10'd12, 10'd16, 10'd8, 10'd44, 10'd120
  };
  localparam logic [1:0] XNum [MaxCols] = '{2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1};
  localparam logic [DivW-1:0] XDen [MaxCols] = '{
    10'd3, 10'd3, 10'd3, 10'd2, 10'd2, 10'd1
  };
  localparam logic [DivW-1:0] ExtDiv [MaxCols-1] = '{
    10'd63, 10'd127, 10'd255, 10'd511, 10'd1023
  };

  typedef enum logic [1:0] {
    KIND_EVAL   = 2'd0,
    KIND_FINAL  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_BASE  = 2'd1,
    SEL_SUB   = 2'd2,
    SEL_POINT = 2'd3
  } sel_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_START, OP_OPEN, OP_STORE, OP_WSUM, OP_MD_Y, OP_PY, OP_MD_X,
    OP_PX, OP_SUBY, OP_INIT, OP_DELTA, OP_MD_E, OP_INT_ADD, OP_CT_STORE, OP_FINISH
  } op_e;

  typedef struct packed {
    logic       in_fire;
    op_e        op;
    logic [2:0] idx;
    logic [2:0] stage;
    logic [2:0] col;
    kind_e      kind;
    sel_e       sel;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic        command;
    logic [15:0] step_count;
    logic [2:0]  columns;
    logic        md_done;
  } dp_stat_t;

  typedef struct packed {
    logic                    start;
    logic signed [WordW-1:0] a;
    logic signed [WordW-1:0] b;
    logic [DivW-1:0]         c;
    logic                    frac;
  } md_req_t;

  function automatic logic signed [WordW-1:0] sat_wide(input logic signed [WideW-1:0] v);
    logic signed [WordW-1:0] r;
    if (v > WideHi) r = WordHi;
    else if (v < WideLo) r = WordLo;
    else r = v[WordW-1:0];
    return r;
  endfunction

  function automatic logic signed [WordW-1:0] sat_add(input logic signed [WordW-1:0] a,
                                                       input logic signed [WordW-1:0] b);
    return sat_wide(WideW'(a) + WideW'(b));
  endfunction

  function automatic logic signed [WordW-1:0] sat_sub(input logic signed [WordW-1:0] a,
                                                       input logic signed [WordW-1:0] b);
    return sat_wide(WideW'(a) - WideW'(b));
  endfunction

endpackage

[rtl/bdr_intf.sv]
interface bdr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic signed [63:0] x_start;
  logic signed [63:0] y_start;
  logic signed [63:0] slope;
  modport source (output valid, command, x_start, y_start, slope, input ready);
  modport sink   (input valid, command, x_start, y_start, slope, output ready);
endinterface

interface bdr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic signed [63:0] point_x;
  logic signed [63:0] point_y;
  modport source (output valid, result_kind, point_x, point_y, input ready);
  modport sink   (input valid, result_kind, point_x, point_y, output ready);
endinterface

interface bdr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/bdr_muldiv.sv]
module bdr_muldiv (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bdr_pkg::md_req_t                      req_i,
  output logic                                  done_o,
  output logic signed [bdr_pkg::WordW-1:0]      q_o
);

  localparam int unsigned W  = bdr_pkg::WordW;
  localparam int unsigned PW = bdr_pkg::ProdW;
  localparam int unsigned HW = W / 2;
  localparam int unsigned DigitBits = 4;
  localparam int unsigned DivSteps  = PW / DigitBits;

  typedef enum logic [4:0] {
    MD_IDLE  = 5'b00001,
    MD_MUL   = 5'b00010,
    MD_ROUND = 5'b00100,
    MD_DIV   = 5'b01000,
    MD_SAT   = 5'b10000
  } md_state_e;

  md_state_e state_q, state_d;
  logic [4:0]                cnt_q, cnt_d;
  logic                      done_q, done_d;
  logic [W-1:0]              ma_q, ma_d, mb_q, mb_d;
  logic [bdr_pkg::DivW-1:0]  c_q, c_d;
  logic                      frac_q, frac_d, neg_q, neg_d;
  logic [PW-1:0]             acc_q, acc_d;
  logic [W-1:0]              pp_q, pp_d;
  logic [bdr_pkg::DivW:0]    rem_q, rem_d;
  logic signed [W-1:0]       q_q, q_d;

  logic [HW-1:0]             a_h, b_h;
  logic [2:0]                pidx;
  logic [1:0]                psh;
  logic [PW-1:0]             half, rsum, acc_t;
  logic [bdr_pkg::DivW:0]    rem_t;
  logic [W-1:0]              lim, mag;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    ma_d    = ma_q;
    mb_d    = mb_q;
    c_d     = c_q;
    frac_d  = frac_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    pp_d    = pp_q;
    rem_d   = rem_q;
    q_d     = q_q;
    a_h     = cnt_q[1] ? ma_q[W-1:HW] : ma_q[HW-1:0];
    b_h     = cnt_q[0] ? mb_q[W-1:HW] : mb_q[HW-1:0];
    pidx    = cnt_q[2:0] - 3'd1;
    psh     = 2'(pidx[1]) + 2'(pidx[0]);
    half    = frac_q ? (PW'(c_q) << (bdr_pkg::FracBits - 1)) : PW'(c_q >> 1);
    rsum    = acc_q + half;
    rem_t   = rem_q;
    acc_t   = acc_q;
    lim     = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    mag     = ((|acc_q[PW-1:W]) || (acc_q[W-1:0] > lim)) ? lim : acc_q[W-1:0];
    for (int i = 0; i < DigitBits; i++) begin
      rem_t = {rem_t[bdr_pkg::DivW-1:0], acc_t[PW-1]};
      acc_t = {acc_t[PW-2:0], 1'b0};
      if (rem_t >= {1'b0, c_q}) begin
        rem_t    = rem_t - {1'b0, c_q};
        acc_t[0] = 1'b1;
      end
    end
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          ma_d    = req_i.a[W-1] ? W'(-req_i.a) : W'(req_i.a);
          mb_d    = req_i.b[W-1] ? W'(-req_i.b) : W'(req_i.b);
          neg_d   = req_i.a[W-1] ^ req_i.b[W-1];
          c_d     = req_i.c;
          frac_d  = req_i.frac;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        pp_d = W'(a_h) * W'(b_h);
        if (cnt_q != 5'd0) acc_d = acc_q + (PW'(pp_q) << {psh, 5'b0});
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd4) state_d = MD_ROUND;
      end
      MD_ROUND: begin
        acc_d   = frac_q ? (rsum >> bdr_pkg::FracBits) : rsum;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = MD_DIV;
      end
      MD_DIV: begin
        acc_d = acc_t;
        rem_d = rem_t;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DivSteps - 1)) state_d = MD_SAT;
      end
      MD_SAT: begin
        q_d     = neg_q ? -$signed(mag) : $signed(mag);
        done_d  = 1'b1;
        state_d = MD_IDLE;
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    c_q    <= c_d;
    frac_q <= frac_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
    pp_q   <= pp_d;
    rem_q  <= rem_d;
    q_q    <= q_d;
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

[rtl/bdr_datapath.sv]
module bdr_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [63:0]                       cfg_data_i,
  input  logic                              command_i,
  input  logic signed [63:0]                x_start_i,
  input  logic signed [63:0]                y_start_i,
  input  logic signed [63:0]                slope_i,
  input  bdr_pkg::dp_cmd_t                  cmd_i,
  output bdr_pkg::dp_stat_t                 stat_o,
  output logic [1:0]                        kind_o,
  output logic signed [63:0]                point_x_o,
  output logic signed [63:0]                point_y_o
);

  localparam int unsigned W = bdr_pkg::WordW;

  logic signed [W-1:0] step_size_q;
  logic [15:0]         step_count_q;
  logic [2:0]          columns_q;

  logic                command_q;
  logic signed [W-1:0] xin_q, yin_q, slope_q;
  logic signed [W-1:0] base_x_q, base_y_q, sub_x_q, sub_y_q, sub_width_q;
  logic signed [W-1:0] wsum_q, px_q, py_q, integral_q, delta_q;
  logic signed [W-1:0] slopes_q [bdr_pkg::NumStages];
  logic signed [W-1:0] ct_q [bdr_pkg::MaxCols];
  logic [1:0]          out_kind_q;
  logic signed [W-1:0] out_x_q, out_y_q;

  bdr_pkg::md_req_t    md_req;
  logic                md_done;
  logic signed [W-1:0] md_q;

  logic signed [7:0]                coef;
  logic signed [bdr_pkg::WideW-1:0] prod;
  logic [W-1:0]                     hmag, hq;
  logic [W:0]                       hsum;
  logic signed [W-1:0]              hw;
  logic [2:0]                       cval;

  always_comb begin
    coef = bdr_pkg::StageCoef[cmd_i.stage][cmd_i.idx];
    prod = bdr_pkg::WideW'(slopes_q[cmd_i.idx]) * bdr_pkg::WideW'(coef);
    hmag = step_size_q[W-1] ? W'(-step_size_q) : W'(step_size_q);
    hsum = (W+1)'(hmag) + ((W+1)'(1) << (cmd_i.idx - 3'd1));
    hq   = W'(hsum >> cmd_i.idx);
    if (cmd_i.idx == 3'd0) hw = step_size_q;
    else hw = step_size_q[W-1] ? -$signed(hq) : $signed(hq);
    cval = cfg_data_i[2:0];
    if (cval == 3'd0) cval = 3'd1;
    else if (cval > 3'(bdr_pkg::MaxCols)) cval = 3'(bdr_pkg::MaxCols);
  end

  always_comb begin
    md_req       = '0;
    md_req.start = 1'b0;
    md_req.a     = sub_width_q;
    md_req.b     = wsum_q;
    md_req.c     = bdr_pkg::StageDiv[cmd_i.stage];
    md_req.frac  = 1'b1;
    unique case (cmd_i.op)
      bdr_pkg::OP_MD_Y: md_req.start = 1'b1;
      bdr_pkg::OP_MD_X: begin
        md_req.start = 1'b1;
        md_req.b     = W'(bdr_pkg::XNum[cmd_i.stage]);
        md_req.c     = bdr_pkg::XDen[cmd_i.stage];
        md_req.frac  = 1'b0;
      end
      bdr_pkg::OP_MD_E: begin
        md_req.start = 1'b1;
        md_req.a     = delta_q;
        md_req.b     = W'(1);
        md_req.c     = bdr_pkg::ExtDiv[cmd_i.idx];
        md_req.frac  = 1'b0;
      end
      default: md_req.start = 1'b0;
    endcase
  end

  bdr_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .done_o (md_done),
    .q_o    (md_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q  <= '0;
      step_count_q <= '0;
      columns_q    <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdr_pkg::CfgStepSize:  step_size_q  <= cfg_data_i;
        bdr_pkg::CfgStepCount: step_count_q <= cfg_data_i[15:0];
        bdr_pkg::CfgColumns:   columns_q    <= cval;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_fire) begin
      command_q <= command_i;
      xin_q     <= x_start_i;
      yin_q     <= y_start_i;
      slope_q   <= slope_i;
    end
    unique case (cmd_i.op)
      bdr_pkg::OP_NONE: ;
      bdr_pkg::OP_START: begin
        base_x_q <= xin_q;
        base_y_q <= yin_q;
      end
      bdr_pkg::OP_OPEN: begin
        sub_width_q <= hw;
        sub_x_q     <= base_x_q;
        sub_y_q     <= base_y_q;
      end
      bdr_pkg::OP_STORE: begin
        slopes_q[cmd_i.stage] <= slope_q;
        wsum_q                <= '0;
      end
      bdr_pkg::OP_WSUM: begin
        if (coef != 8'sd0) wsum_q <= bdr_pkg::sat_add(wsum_q, bdr_pkg::sat_wide(prod));
      end
      bdr_pkg::OP_MD_Y: ;
      bdr_pkg::OP_PY:   py_q <= bdr_pkg::sat_add(sub_y_q, md_q);
      bdr_pkg::OP_MD_X: ;
      bdr_pkg::OP_PX:   px_q <= bdr_pkg::sat_add(sub_x_q, md_q);
      bdr_pkg::OP_SUBY: begin
        sub_y_q <= bdr_pkg::sat_add(sub_y_q, md_q);
        sub_x_q <= bdr_pkg::sat_add(sub_x_q, sub_width_q);
      end
      bdr_pkg::OP_INIT: integral_q <= sub_y_q;
      bdr_pkg::OP_DELTA: begin
        delta_q          <= bdr_pkg::sat_sub(integral_q, ct_q[cmd_i.idx]);
        ct_q[cmd_i.idx]  <= integral_q;
      end
      bdr_pkg::OP_MD_E: ;
      bdr_pkg::OP_INT_ADD:  integral_q <= bdr_pkg::sat_add(integral_q, md_q);
      bdr_pkg::OP_CT_STORE: ct_q[cmd_i.col] <= integral_q;
      bdr_pkg::OP_FINISH: begin
        base_y_q <= integral_q;
        base_x_q <= bdr_pkg::sat_add(base_x_q, step_size_q);
      end
    endcase
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.kind;
      unique case (cmd_i.sel)
        bdr_pkg::SEL_ZERO: begin
          out_x_q <= '0;
          out_y_q <= '0;
        end
        bdr_pkg::SEL_BASE: begin
          out_x_q <= base_x_q;
          out_y_q <= base_y_q;
        end
        bdr_pkg::SEL_SUB: begin
          out_x_q <= sub_x_q;
          out_y_q <= sub_y_q;
        end
        bdr_pkg::SEL_POINT: begin
          out_x_q <= px_q;
          out_y_q <= py_q;
        end
      endcase
    end
  end

  assign stat_o.command    = command_q;
  assign stat_o.step_count = step_count_q;
  assign stat_o.columns    = columns_q;
  assign stat_o.md_done    = md_done;
  assign kind_o            = out_kind_q;
  assign point_x_o         = out_x_q;
  assign point_y_o         = out_y_q;

endmodule

[rtl/bdr_ctrl.sv]
module bdr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bdr_pkg::dp_stat_t  stat_i,
  output bdr_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DISPATCH = 14'b00000000000010,
    S_AFTER    = 14'b00000000000100,
    S_WSUM     = 14'b00000000001000,
    S_MDY_GO   = 14'b00000000010000,
    S_MDY      = 14'b00000000100000,
    S_MDX_GO   = 14'b00000001000000,
    S_MDX      = 14'b00000010000000,
    S_SUBCHK   = 14'b00000100000000,
    S_EXT      = 14'b00001000000000,
    S_MDE_GO   = 14'b00010000000000,
    S_MDE      = 14'b00100000000000,
    S_NEXTCOL  = 14'b01000000000000,
    S_EMIT     = 14'b10000000000000
  } state_e;

  state_e          state_q, state_d;
  logic [2:0]      stage_q, stage_d, col_q, col_d, cnt_q, cnt_d;
  logic [5:0]      sub_left_q, sub_left_d;
  logic [15:0]     steps_q, steps_d;
  logic            busy_q, busy_d, out_valid_q, out_valid_d;
  bdr_pkg::kind_e  kind_q, kind_d;
  bdr_pkg::sel_e   sel_q, sel_d;
  logic [3:0]      next_col;

  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    sub_left_d  = sub_left_q;
    steps_d     = steps_q;
    busy_d      = busy_q;
    kind_d      = kind_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    next_col    = {1'b0, col_q} + 4'd1;
    cmd_o          = '0;
    cmd_o.op       = bdr_pkg::OP_NONE;
    cmd_o.idx      = cnt_q;
    cmd_o.stage    = stage_q;
    cmd_o.col      = col_q;
    cmd_o.kind     = kind_q;
    cmd_o.sel      = sel_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_fire = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.command != busy_q) begin
          // start while busy or slope while idle
          kind_d  = bdr_pkg::KIND_REJECT;
          sel_d   = bdr_pkg::SEL_ZERO;
          state_d = S_EMIT;
        end else if (!stat_i.command) begin
          cmd_o.op = bdr_pkg::OP_START;
          steps_d  = stat_i.step_count;
          state_d  = S_AFTER;
        end else begin
          cmd_o.op = bdr_pkg::OP_STORE;
          cnt_d    = '0;
          state_d  = S_WSUM;
        end
      end
      S_WSUM: begin
        cmd_o.op = bdr_pkg::OP_WSUM;
        if (cnt_q == 3'(bdr_pkg::NumStages - 1)) state_d = S_MDY_GO;
        else cnt_d = cnt_q + 3'd1;
      end
      S_MDY_GO: begin
        cmd_o.op = bdr_pkg::OP_MD_Y;
        state_d  = S_MDY;
      end
      S_MDY: begin
        if (stat_i.md_done) begin
          if (stage_q < 3'(bdr_pkg::NumStages - 1)) begin
            cmd_o.op = bdr_pkg::OP_PY;
            state_d  = S_MDX_GO;
          end else begin
            cmd_o.op = bdr_pkg::OP_SUBY;
            stage_d  = '0;
            if (sub_left_q != 6'd0) sub_left_d = sub_left_q - 6'd1;
            state_d  = S_SUBCHK;
          end
        end
      end
      S_MDX_GO: begin
        cmd_o.op = bdr_pkg::OP_MD_X;
        state_d  = S_MDX;
      end
      S_MDX: begin
        if (stat_i.md_done) begin
          cmd_o.op = bdr_pkg::OP_PX;
          stage_d  = stage_q + 3'd1;
          kind_d   = bdr_pkg::KIND_EVAL;
          sel_d    = bdr_pkg::SEL_POINT;
          state_d  = S_EMIT;
        end
      end
      S_SUBCHK: begin
        if (sub_left_q != 6'd0) begin
          kind_d  = bdr_pkg::KIND_EVAL;
          sel_d   = bdr_pkg::SEL_SUB;
          state_d = S_EMIT;
        end else begin
          cmd_o.op = bdr_pkg::OP_INIT;
          cnt_d    = '0;
          state_d  = S_EXT;
        end
      end
      S_EXT: begin
        if (cnt_q < col_q) begin
          cmd_o.op = bdr_pkg::OP_DELTA;
          state_d  = S_MDE_GO;
        end else begin
          cmd_o.op = bdr_pkg::OP_CT_STORE;
          state_d  = S_NEXTCOL;
        end
      end
      S_MDE_GO: begin
        cmd_o.op = bdr_pkg::OP_MD_E;
        state_d  = S_MDE;
      end
      S_MDE: begin
        if (stat_i.md_done) begin
          cmd_o.op = bdr_pkg::OP_INT_ADD;
          cnt_d    = cnt_q + 3'd1;
          state_d  = S_EXT;
        end
      end
      S_NEXTCOL: begin
        if (next_col < {1'b0, stat_i.columns} && next_col < 4'(bdr_pkg::MaxCols)) begin
          cmd_o.op   = bdr_pkg::OP_OPEN;
          cmd_o.idx  = next_col[2:0];
          col_d      = next_col[2:0];
          sub_left_d = 6'd1 << next_col[2:0];
          stage_d    = '0;
          kind_d     = bdr_pkg::KIND_EVAL;
          sel_d      = bdr_pkg::SEL_SUB;
          state_d    = S_EMIT;
        end else begin
          cmd_o.op = bdr_pkg::OP_FINISH;
          if (steps_q != 16'd0) steps_d = steps_q - 16'd1;
          state_d  = S_AFTER;
        end
      end
      S_AFTER: begin
        if (steps_q == 16'd0) begin
          busy_d = 1'b0;
          kind_d = bdr_pkg::KIND_FINAL;
          sel_d  = bdr_pkg::SEL_BASE;
        end else begin
          busy_d     = 1'b1;
          cmd_o.op   = bdr_pkg::OP_OPEN;
          cmd_o.idx  = '0;
          col_d      = '0;
          sub_left_d = 6'd1;
          stage_d    = '0;
          kind_d     = bdr_pkg::KIND_EVAL;
          sel_d      = bdr_pkg::SEL_SUB;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stage_q     <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      sub_left_q  <= '0;
      steps_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= bdr_pkg::KIND_EVAL;
      sel_q       <= bdr_pkg::SEL_ZERO;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      sub_left_q  <= sub_left_d;
      steps_q     <= steps_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      sel_q       <= sel_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/butcher_ode_step_richardson.sv]
// channel | dir | beat payload                        | accepted when
// in_i    | in  | command, x_start, y_start, slope    | valid && ready
// out_o   | out | result_kind, point_x, point_y       | valid && ready
// cfg_i   | in  | index (0 h, 1 count, 2 columns), data | valid && ready (ready tied high)
// Rejected beats go from dispatch to emit; start beats pass the after-step state first.
// A slope beat runs a weighted sum over the seven stored slopes, then the shared
// multiply-divide unit (multiply, round, radix-16 divide, saturate) twice, once at the
// last stage. A slope closing a column adds one extrapolation pass per earlier column.
// Reset is asynchronous, active low; no clearing pass. A stalled output beat holds,
// and the next input beat is taken while it waits.
module butcher_ode_step_richardson (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdr_in_if.sink     in_i,
  bdr_out_if.source  out_o,
  bdr_cfg_if.sink    cfg_i
);

  bdr_pkg::dp_cmd_t  cmd;
  bdr_pkg::dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  bdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bdr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .command_i  (in_i.command),
    .x_start_i  (in_i.x_start),
    .y_start_i  (in_i.y_start),
    .slope_i    (in_i.slope),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .kind_o     (out_o.result_kind),
    .point_x_o  (out_o.point_x),
    .point_y_o  (out_o.point_y)
  );

endmodule

[rtl/bdr_checker.sv]
module bdr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [63:0] x_i,
  input logic [63:0] y_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(x_i)
      && $stable(y_i))
    else $error("stalled output beat changed");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> kind_i != 2'd3)
    else $error("illegal result kind");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == 2'd2 |-> x_i == 64'd0 && y_i == 64'd0)
    else $error("rejected beat carries a point");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("config write stalled");

endmodule

bind butcher_ode_step_richardson bdr_checker u_bdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.result_kind),
  .x_i         (out_o.point_x),
  .y_i         (out_o.point_y)
);
